FILE: rtl/core/smm_pkg.sv
// Shared types and constants for the square matrix multiplier.
package smm_pkg;

   localparam int DATA_W = 32;
   localparam int DIM_W  = 4;
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_WAIT,
      ST_SEND
   } state_type;

   // Control that travels alongside one pair of operands read from the stores.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // Finished dot product leaving the multiply-accumulate unit.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
   } mac_res_type;

endpackage

FILE: rtl/core/square_matrix_multiply.sv
// Square matrix multiplier top level: load sequencer, operand stores and result register.
//
// The block multiplies two signed n-by-n integer matrices, n taken from the
// dimension register (0 acts as 1, values above MAX_DIM act as MAX_DIM). Send
// the elements of the first matrix row-major, then those of the second, one
// item per element; each element is written into one of two on-chip stores
// as it arrives, so loading runs at one item per cycle. After the last
// element of the second matrix the block stops taking items and produces the
// n*n product elements row-major, the final one flagged by rsp_last. Each
// product element is a dot product computed by reading one row entry and one
// column entry from the stores per cycle into a single registered multiplier
// and a wrapping 32-bit accumulator; the reads pass through three pipeline
// stages (store read, product, accumulator) into the output register. Product
// elements are computed one at a time through the single multiply-accumulate
// path and the one read port of each store; no items are taken until the
// last product element has left. Change the dimension only while no job is
// in flight; the configuration port is always ready.
module square_matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [smm_pkg::DATA_W-1:0]  req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [smm_pkg::DATA_W-1:0]  rsp_product,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smm_pkg::DIM_W-1:0]          csr_dimension
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NW    = $clog2(MAX_DIM + 1);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LW    = $clog2(2 * DEPTH + 1);

   smm_pkg::state_type state_ff, state_in;

   logic [smm_pkg::DIM_W-1:0] dim_ff, dim_in;
   logic [LW-1:0]             load_count_ff, load_count_in;
   logic [IW-1:0]             i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0]             row_base_ff, row_base_in;
   logic [AW-1:0]             a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   smm_pkg::mac_ctl_type      rd_ctl_ff, rd_ctl_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [smm_pkg::DATA_W-1:0] rsp_product_ff, rsp_product_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [NW-1:0] n_eff, n_m1;
   logic [CW-1:0] cells;
   logic [LW-1:0] cells2, load_base, load_next, right_off;
   logic [AW-1:0] n_aw;
   logic          req_acc, rsp_acc, to_left, load_done, k_last, elem_last, issue;

   logic [smm_pkg::DATA_W-1:0] left_q, right_q;
   smm_pkg::mac_res_type       mac_res;

   // Effective dimension and the element count of one matrix.
   always_comb begin
      if (dim_ff == '0) begin
         n_eff = NW'(1);
      end else if (dim_ff > smm_pkg::DIM_W'(MAX_DIM)) begin
         n_eff = NW'(MAX_DIM);
      end else begin
         n_eff = NW'(dim_ff);
      end
   end

   assign n_m1   = n_eff - NW'(1);
   assign n_aw   = AW'(n_eff);
   assign cells  = CW'(n_eff) * CW'(n_eff);
   assign cells2 = LW'({cells, 1'b0});

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid_ff && !rsp_stall;

   // A count left beyond the job size by a dimension change starts over.
   assign load_base = (load_count_ff >= cells2) ? '0 : load_count_ff;
   assign to_left   = load_base < LW'(cells);
   assign right_off = load_base - LW'(cells);
   assign load_next = load_base + LW'(1);
   assign load_done = load_next == cells2;

   assign k_last    = NW'(k_ff) == n_m1;
   assign elem_last = (NW'(i_ff) == n_m1) && (NW'(j_ff) == n_m1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smm_pkg::ST_LOAD: begin
            if (req_acc && load_done) begin
               state_in = smm_pkg::ST_CALC;
            end
         end
         smm_pkg::ST_CALC: begin
            if (k_last) begin
               state_in = smm_pkg::ST_WAIT;
            end
         end
         smm_pkg::ST_WAIT: begin
            if (mac_res.valid) begin
               state_in = smm_pkg::ST_SEND;
            end
         end
         smm_pkg::ST_SEND: begin
            if (rsp_acc) begin
               state_in = rsp_last_ff ? smm_pkg::ST_LOAD : smm_pkg::ST_CALC;
            end
         end
         default: state_in = smm_pkg::ST_LOAD;
      endcase
   end

   // State-decoded outputs.
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      case (state_ff)
         smm_pkg::ST_LOAD: req_stall = 1'b0;
         smm_pkg::ST_CALC: issue     = 1'b1;
         smm_pkg::ST_WAIT: req_stall = 1'b1;
         smm_pkg::ST_SEND: req_stall = 1'b1;
         default:          req_stall = 1'b1;
      endcase
   end

   // Load count, loop indexes and store read addresses. The row entry address
   // steps by one and the column entry address by n along the dot product.
   always_comb begin
      load_count_in = load_count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      row_base_in   = row_base_ff;
      a_addr_in     = a_addr_ff;
      b_addr_in     = b_addr_ff;
      case (state_ff)
         smm_pkg::ST_LOAD: begin
            if (req_acc) begin
               load_count_in = load_done ? '0 : load_next;
               if (load_done) begin
                  i_in        = '0;
                  j_in        = '0;
                  k_in        = '0;
                  row_base_in = '0;
                  a_addr_in   = '0;
                  b_addr_in   = '0;
               end
            end
         end
         smm_pkg::ST_CALC: begin
            if (k_last) begin
               k_in = '0;
            end else begin
               k_in      = k_ff + IW'(1);
               a_addr_in = a_addr_ff + AW'(1);
               b_addr_in = b_addr_ff + n_aw;
            end
         end
         smm_pkg::ST_WAIT: begin
            k_in = '0;
         end
         smm_pkg::ST_SEND: begin
            if (rsp_acc && !rsp_last_ff) begin
               if (NW'(j_ff) == n_m1) begin
                  j_in        = '0;
                  i_in        = i_ff + IW'(1);
                  row_base_in = row_base_ff + n_aw;
                  a_addr_in   = row_base_ff + n_aw;
                  b_addr_in   = '0;
               end else begin
                  j_in      = j_ff + IW'(1);
                  a_addr_in = row_base_ff;
                  b_addr_in = AW'(j_ff) + AW'(1);
               end
            end
         end
         default: load_count_in = '0;
      endcase
   end

   // Control for the operand pair that the stores return next cycle.
   always_comb begin
      rd_ctl_in.valid = issue;
      rd_ctl_in.first = k_ff == '0;
      rd_ctl_in.last  = k_last;
   end

   // Output register: filled by a finished dot product, emptied by the consumer.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_product_in = rsp_product_ff;
      rsp_last_in    = rsp_last_ff;
      if ((state_ff == smm_pkg::ST_WAIT) && mac_res.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_product_in = mac_res.value;
         rsp_last_in    = elem_last;
      end else if (rsp_acc) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign dim_in = (csr_valid && csr_ready) ? csr_dimension : dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smm_pkg::ST_LOAD;
         dim_ff        <= smm_pkg::DIM_RESET;
         load_count_ff <= '0;
         rd_ctl_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dim_ff        <= dim_in;
         load_count_ff <= load_count_in;
         rd_ctl_ff     <= rd_ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      row_base_ff    <= row_base_in;
      a_addr_ff      <= a_addr_in;
      b_addr_ff      <= b_addr_in;
      rsp_product_ff <= rsp_product_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // First matrix store, written during the first half of a load.
   smm_ram #(
      .WIDTH(smm_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_left_ram (
      .clock  (clock),
      .wr_en  (req_acc && to_left),
      .wr_addr(load_base[AW-1:0]),
      .wr_data(req_element),
      .rd_addr(a_addr_ff),
      .rd_data(left_q)
   );

   // Second matrix store, written during the second half of a load.
   smm_ram #(
      .WIDTH(smm_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_right_ram (
      .clock  (clock),
      .wr_en  (req_acc && !to_left),
      .wr_addr(right_off[AW-1:0]),
      .wr_data(req_element),
      .rd_addr(b_addr_ff),
      .rd_data(right_q)
   );

   smm_mac u_smm_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rd_ctl_ff),
      .left_data (left_q),
      .right_data(right_q),
      .res       (mac_res)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_last    = rsp_last_ff;
   assign csr_ready   = 1'b1;

endmodule

FILE: rtl/core/smm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/smm_mac.sv
// Multiply-accumulate unit: registered 32-bit product, then a wrapping accumulator.
module smm_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  smm_pkg::mac_ctl_type           ctl,
   input  logic [smm_pkg::DATA_W-1:0]     left_data,
   input  logic [smm_pkg::DATA_W-1:0]     right_data,
   output smm_pkg::mac_res_type           res
);

   logic [smm_pkg::DATA_W-1:0] mul_ff, mul_in;
   smm_pkg::mac_ctl_type       mul_ctl_ff;
   logic [smm_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                       done_ff, done_in;

   // Only the low word of the product matters, and it is the same for
   // signed and unsigned operands.
   assign mul_in = left_data * right_data;

   always_comb begin
      acc_in = acc_ff;
      if (mul_ctl_ff.valid) begin
         acc_in = (mul_ctl_ff.first ? '0 : acc_ff) + mul_ff;
      end
      done_in = mul_ctl_ff.valid && mul_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         mul_ctl_ff <= ctl;
         done_ff    <= done_in;
      end
      mul_ff <= mul_in;
      acc_ff <= acc_in;
   end

   assign res.valid = done_ff;
   assign res.value = acc_ff;

endmodule

FILE: rtl/core/smm_checker.sv
// Port-level checker for the square matrix multiplier and its bind.
module smm_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [smm_pkg::DATA_W-1:0]  rsp_product,
   input logic                               rsp_last
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product) && $stable(rsp_last))
      else $error("stalled result changed");

   // No item is taken while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while a result was pending");

   // Taking an item never produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result appeared right after an item");

   // Once the last product element leaves, loading resumes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !req_stall && !rsp_valid)
      else $error("block did not return to loading after the last element");

endmodule

bind square_matrix_multiply smm_port_checker u_smm_port_checker (.*);
